>>> hdl/pwsp_pkg.sv
// Shared types, codes and constants of the peer wire stream parser.
`timescale 1ns / 1ps
package pwsp_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_INFO_HASH_HIGH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFO_HASH_MIDDLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFO_HASH_LOW    = 2'd2;

   localparam logic [2:0] KIND_PEER_ID    = 3'd0;
   localparam logic [2:0] KIND_KEEP_ALIVE = 3'd1;
   localparam logic [2:0] KIND_HEADER     = 3'd2;
   localparam logic [2:0] KIND_DATA       = 3'd3;
   localparam logic [2:0] KIND_ERROR      = 3'd4;

   localparam logic [1:0] ERR_HASH_MISMATCH = 2'd0;
   localparam logic [1:0] ERR_NOT_PIECE     = 2'd1;
   localparam logic [1:0] ERR_SHORT_PIECE   = 2'd2;

   localparam logic [7:0]  PIECE_ID         = 8'd7;
   localparam logic [31:0] HASH_BYTES       = 32'd20;
   localparam logic [31:0] RESERVED_BYTES   = 32'd8;
   localparam logic [31:0] LENGTH_BYTES     = 32'd4;
   localparam logic [31:0] PIECE_HEADER_END = 32'd9;

   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = 2;
   localparam int unsigned Q_CNT_W = 3;

   typedef enum logic [2:0] {
      PH_PLEN,
      PH_SKIP,
      PH_HASH,
      PH_PEERID,
      PH_LEN,
      PH_BODY,
      PH_DEAD
   } phase_type;

   typedef struct packed {
      logic [63:0] info_hash_high;
      logic [63:0] info_hash_middle;
      logic [31:0] info_hash_low;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [31:0] piece_index;
      logic [31:0] block_offset;
      logic        last;
      logic [1:0]  error_code;
      logic [7:0]  message_id;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      phase_type phase;
      logic      push;
   } front_status_type;

   function automatic logic [7:0] hash_byte(input cfg_type cfg, input logic [4:0] k);
      logic [159:0] hv;
      logic [7:0]   top_bit;
      hv      = {cfg.info_hash_high, cfg.info_hash_middle, cfg.info_hash_low};
      top_bit = 8'd159 - {k, 3'b000};
      return hv[top_bit -: 8];
   endfunction

endpackage

>>> hdl/peer_wire_stream_parser.sv
// Path: a result enters the result queue when its beat is accepted, then the output register.
// Throughput: one beat per cycle; req_ready falls only while the four-entry result
// queue is full, which happens when rsp_ready stays low.
// Reset: synchronous, active high; clears parse state, info hash registers and queue.
// Top level of the peer wire stream parser.
`timescale 1ns / 1ps
module peer_wire_stream_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_kind,
   output logic [7:0]                         rsp_data_byte,
   output logic [31:0]                        rsp_piece_index,
   output logic [31:0]                        rsp_block_offset,
   output logic                               rsp_last,
   output logic [1:0]                         rsp_error_code,
   output logic [7:0]                         rsp_message_id,
   input  logic                               csr_we,
   input  logic [pwsp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pwsp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pwsp_pkg::cfg_type          cfg_ff, cfg_in;
   pwsp_pkg::q_status_type     q_stat;
   pwsp_pkg::front_status_type f_stat;
   pwsp_pkg::rsp_type          push_data;
   pwsp_pkg::rsp_type          pop_data;
   pwsp_pkg::rsp_type          rsp_data;
   logic                       push;
   logic                       pop;
   logic                       beat;

   assign req_ready = !q_stat.full;
   assign beat      = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pwsp_pkg::CSR_INFO_HASH_HIGH:   cfg_in.info_hash_high   = csr_wdata;
            pwsp_pkg::CSR_INFO_HASH_MIDDLE: cfg_in.info_hash_middle = csr_wdata;
            pwsp_pkg::CSR_INFO_HASH_LOW:    cfg_in.info_hash_low    = csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pwsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .req_action  (req_action),
      .req_rx_byte (req_rx_byte),
      .cfg         (cfg_ff),
      .push        (push),
      .push_data   (push_data),
      .status      (f_stat)
   );

   pwsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_stat)
   );

   pwsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_stat),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_data_byte    = rsp_data.data_byte;
   assign rsp_piece_index  = rsp_data.piece_index;
   assign rsp_block_offset = rsp_data.block_offset;
   assign rsp_last         = rsp_data.last;
   assign rsp_error_code   = rsp_data.error_code;
   assign rsp_message_id   = rsp_data.message_id;

   a_dead_silent: assert property (@(posedge clock) disable iff (reset)
      (f_stat.phase == pwsp_pkg::PH_DEAD) |-> !f_stat.push)
      else $error("result produced after info hash mismatch");

   a_peer_id_ends: assert property (@(posedge clock) disable iff (reset)
      (push && (push_data.kind == pwsp_pkg::KIND_PEER_ID) && push_data.last)
      |=> (f_stat.phase == pwsp_pkg::PH_LEN))
      else $error("last peer id byte did not start message framing");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != pwsp_pkg::KIND_ERROR))
      |-> ((rsp_error_code == pwsp_pkg::ERR_HASH_MISMATCH) && (rsp_message_id == 8'd0)))
      else $error("error fields set on a non-error result");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("result pushed into a full queue");

endmodule

>>> hdl/pwsp_front.sv
// Front end: accepts beats, tracks the handshake and message framing, builds results.
`timescale 1ns / 1ps
module pwsp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       beat,
   input  logic                       req_action,
   input  logic [7:0]                 req_rx_byte,
   input  pwsp_pkg::cfg_type          cfg,
   output logic                       push,
   output pwsp_pkg::rsp_type          push_data,
   output pwsp_pkg::front_status_type status
);

   pwsp_pkg::phase_type phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  strlen_ff, strlen_in;
   logic        mism_ff, mism_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] idx_ff, idx_in;
   logic [31:0] off_ff, off_in;
   logic [7:0]  mid_ff, mid_in;

   logic [31:0] cnt_inc;
   logic        mism_next;
   logic        hash_done;
   logic        peer_last;
   logic [31:0] len_next;
   logic        len_done;
   logic        body_last;
   logic [31:0] idx_next;
   logic [31:0] off_next;
   logic        step;

   assign step      = beat && !req_action;
   assign cnt_inc   = count_ff + 32'd1;
   assign mism_next = mism_ff || (req_rx_byte != pwsp_pkg::hash_byte(cfg, count_ff[4:0]));
   assign hash_done = cnt_inc >= pwsp_pkg::HASH_BYTES;
   assign peer_last = cnt_inc >= pwsp_pkg::HASH_BYTES;
   assign len_next  = {len_ff[23:0], req_rx_byte};
   assign len_done  = cnt_inc >= pwsp_pkg::LENGTH_BYTES;
   assign body_last = count_ff == (len_ff - 32'd1);
   assign idx_next  = {idx_ff[23:0], req_rx_byte};
   assign off_next  = {off_ff[23:0], req_rx_byte};

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      strlen_in = strlen_ff;
      mism_in   = mism_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      off_in    = off_ff;
      mid_in    = mid_ff;
      if (beat && req_action) begin
         phase_in  = pwsp_pkg::PH_PLEN;
         count_in  = '0;
         strlen_in = '0;
         mism_in   = 1'b0;
         len_in    = '0;
         idx_in    = '0;
         off_in    = '0;
         mid_in    = '0;
      end else if (step) begin
         case (phase_ff)
            pwsp_pkg::PH_PLEN: begin
               strlen_in = req_rx_byte;
               count_in  = '0;
               phase_in  = pwsp_pkg::PH_SKIP;
            end
            pwsp_pkg::PH_SKIP: begin
               count_in = cnt_inc;
               if (cnt_inc >= ({24'd0, strlen_ff} + pwsp_pkg::RESERVED_BYTES)) begin
                  count_in = '0;
                  mism_in  = 1'b0;
                  phase_in = pwsp_pkg::PH_HASH;
               end
            end
            pwsp_pkg::PH_HASH: begin
               mism_in  = mism_next;
               count_in = cnt_inc;
               if (hash_done) begin
                  count_in = '0;
                  phase_in = mism_next ? pwsp_pkg::PH_DEAD : pwsp_pkg::PH_PEERID;
               end
            end
            pwsp_pkg::PH_PEERID: begin
               count_in = cnt_inc;
               if (peer_last) begin
                  count_in = '0;
                  len_in   = '0;
                  phase_in = pwsp_pkg::PH_LEN;
               end
            end
            pwsp_pkg::PH_LEN: begin
               len_in   = len_next;
               count_in = cnt_inc;
               if (len_done) begin
                  count_in = '0;
                  if (len_next != 32'd0) begin
                     phase_in = pwsp_pkg::PH_BODY;
                  end
               end
            end
            pwsp_pkg::PH_BODY: begin
               count_in = cnt_inc;
               if (body_last) begin
                  count_in = '0;
                  len_in   = '0;
                  phase_in = pwsp_pkg::PH_LEN;
               end
               if (count_ff == 32'd0) begin
                  mid_in = req_rx_byte;
               end else if (mid_ff == pwsp_pkg::PIECE_ID) begin
                  if (count_ff <= 32'd4) begin
                     idx_in = idx_next;
                  end else if (count_ff <= 32'd8) begin
                     off_in = off_next;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      push      = 1'b0;
      push_data = '0;
      if (step) begin
         case (phase_ff)
            pwsp_pkg::PH_HASH: begin
               if (hash_done && mism_next) begin
                  push                 = 1'b1;
                  push_data.kind       = pwsp_pkg::KIND_ERROR;
                  push_data.error_code = pwsp_pkg::ERR_HASH_MISMATCH;
               end
            end
            pwsp_pkg::PH_PEERID: begin
               push                = 1'b1;
               push_data.kind      = pwsp_pkg::KIND_PEER_ID;
               push_data.data_byte = req_rx_byte;
               push_data.last      = peer_last;
            end
            pwsp_pkg::PH_LEN: begin
               if (len_done && (len_next == 32'd0)) begin
                  push           = 1'b1;
                  push_data.kind = pwsp_pkg::KIND_KEEP_ALIVE;
               end
            end
            pwsp_pkg::PH_BODY: begin
               if (count_ff == 32'd0) begin
                  if (req_rx_byte != pwsp_pkg::PIECE_ID) begin
                     push                 = 1'b1;
                     push_data.kind       = pwsp_pkg::KIND_ERROR;
                     push_data.error_code = pwsp_pkg::ERR_NOT_PIECE;
                     push_data.message_id = req_rx_byte;
                  end else if (body_last) begin
                     push                 = 1'b1;
                     push_data.kind       = pwsp_pkg::KIND_ERROR;
                     push_data.error_code = pwsp_pkg::ERR_SHORT_PIECE;
                     push_data.message_id = pwsp_pkg::PIECE_ID;
                  end
               end else if (mid_ff == pwsp_pkg::PIECE_ID) begin
                  if ((count_ff + 32'd1) < pwsp_pkg::PIECE_HEADER_END) begin
                     if (body_last) begin
                        push                 = 1'b1;
                        push_data.kind       = pwsp_pkg::KIND_ERROR;
                        push_data.error_code = pwsp_pkg::ERR_SHORT_PIECE;
                        push_data.message_id = pwsp_pkg::PIECE_ID;
                     end
                  end else if ((count_ff + 32'd1) == pwsp_pkg::PIECE_HEADER_END) begin
                     push                   = 1'b1;
                     push_data.kind         = pwsp_pkg::KIND_HEADER;
                     push_data.piece_index  = idx_ff;
                     push_data.block_offset = off_next;
                     push_data.last         = body_last;
                  end else begin
                     push                = 1'b1;
                     push_data.kind      = pwsp_pkg::KIND_DATA;
                     push_data.data_byte = req_rx_byte;
                     push_data.last      = body_last;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign status.phase = phase_ff;
   assign status.push  = push;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pwsp_pkg::PH_PLEN;
         count_ff  <= '0;
         strlen_ff <= '0;
         mism_ff   <= 1'b0;
         len_ff    <= '0;
         idx_ff    <= '0;
         off_ff    <= '0;
         mid_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         strlen_ff <= strlen_in;
         mism_ff   <= mism_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         off_ff    <= off_in;
         mid_ff    <= mid_in;
      end
   end

endmodule

>>> hdl/pwsp_queue.sv
// Result queue between the front end and the output stage.
`timescale 1ns / 1ps
module pwsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pwsp_pkg::rsp_type      push_data,
   input  logic                   pop,
   output pwsp_pkg::rsp_type      pop_data,
   output pwsp_pkg::q_status_type status
);

   pwsp_pkg::rsp_type entries_ff [pwsp_pkg::Q_DEPTH];
   logic [pwsp_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pwsp_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pwsp_pkg::Q_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + pwsp_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + pwsp_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + pwsp_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - pwsp_pkg::Q_CNT_W'(1);
      end
   end

   assign pop_data     = entries_ff[rd_ptr_ff];
   assign status.full  = count_ff == pwsp_pkg::Q_CNT_W'(pwsp_pkg::Q_DEPTH);
   assign status.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/pwsp_back.sv
// Output stage: draws results from the queue and holds them on the response channel.
`timescale 1ns / 1ps
module pwsp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  pwsp_pkg::q_status_type q_status,
   input  pwsp_pkg::rsp_type      pop_data,
   output logic                   pop,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output pwsp_pkg::rsp_type      rsp_data
);

   logic              valid_ff, valid_in;
   pwsp_pkg::rsp_type data_ff, data_in;

   assign pop      = !q_status.empty && (!valid_ff || rsp_ready);
   assign valid_in = pop || (valid_ff && !rsp_ready);
   assign data_in  = pop ? pop_data : data_ff;

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

>>> tb/sv/peer_wire_stream_checker.sv
// Result predictor and comparator for the peer wire stream parser testbench.
`timescale 1ns / 1ps
module peer_wire_stream_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_action,
   input  logic [7:0]                       req_rx_byte,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [2:0]                       rsp_kind,
   input  logic [7:0]                       rsp_data_byte,
   input  logic [31:0]                      rsp_piece_index,
   input  logic [31:0]                      rsp_block_offset,
   input  logic                             rsp_last,
   input  logic [1:0]                       rsp_error_code,
   input  logic [7:0]                       rsp_message_id,
   input  logic                             csr_we,
   input  logic [pwsp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwsp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                      mismatch_count,
   output int unsigned                      results_due,
   output int unsigned                      results_checked
);

   pwsp_pkg::phase_type wire_phase;
   logic [31:0]         beat_count;
   logic [31:0]         msg_len;
   logic [31:0]         piece_idx;
   logic [31:0]         piece_off;
   logic [7:0]          name_len;
   logic [7:0]          msg_id;
   logic                hash_bad;
   logic [159:0]        want_hash;
   pwsp_pkg::rsp_type   due_q[$];
   int unsigned         miss_total = 0;
   int unsigned         seen_total = 0;

   function automatic logic [7:0] hash_at(input logic [31:0] k);
      logic [159:0] shifted;
      shifted = want_hash >> (8 * (19 - k));
      return shifted[7:0];
   endfunction

   task automatic restart_parse();
      wire_phase = pwsp_pkg::PH_PLEN;
      beat_count = '0;
      msg_len    = '0;
      piece_idx  = '0;
      piece_off  = '0;
      name_len   = '0;
      msg_id     = '0;
      hash_bad   = 1'b0;
   endtask

   task automatic queue_result(input logic [2:0] kind, input logic [7:0] data,
                               input logic [31:0] idx, input logic [31:0] off,
                               input logic fin, input logic [1:0] code,
                               input logic [7:0] id);
      pwsp_pkg::rsp_type r;
      r.kind         = kind;
      r.data_byte    = data;
      r.piece_index  = idx;
      r.block_offset = off;
      r.last         = fin;
      r.error_code   = code;
      r.message_id   = id;
      due_q = {due_q, r};
   endtask

   task automatic follow_beat(input logic act, input logic [7:0] b);
      logic [31:0] pos;
      logic        fin;
      if (act) begin
         restart_parse();
      end else begin
         case (wire_phase)
            pwsp_pkg::PH_PLEN: begin
               name_len   = b;
               beat_count = '0;
               wire_phase = pwsp_pkg::PH_SKIP;
            end
            pwsp_pkg::PH_SKIP: begin
               beat_count = beat_count + 1;
               if (beat_count >= {24'd0, name_len} + pwsp_pkg::RESERVED_BYTES) begin
                  beat_count = '0;
                  hash_bad   = 1'b0;
                  wire_phase = pwsp_pkg::PH_HASH;
               end
            end
            pwsp_pkg::PH_HASH: begin
               if (b != hash_at(beat_count)) hash_bad = 1'b1;
               beat_count = beat_count + 1;
               if (beat_count >= pwsp_pkg::HASH_BYTES) begin
                  beat_count = '0;
                  if (hash_bad) begin
                     wire_phase = pwsp_pkg::PH_DEAD;
                     queue_result(pwsp_pkg::KIND_ERROR, 8'd0, '0, '0, 1'b0,
                                  pwsp_pkg::ERR_HASH_MISMATCH, 8'd0);
                  end else begin
                     wire_phase = pwsp_pkg::PH_PEERID;
                  end
               end
            end
            pwsp_pkg::PH_PEERID: begin
               beat_count = beat_count + 1;
               fin = (beat_count >= pwsp_pkg::HASH_BYTES);
               if (fin) begin
                  beat_count = '0;
                  msg_len    = '0;
                  wire_phase = pwsp_pkg::PH_LEN;
               end
               queue_result(pwsp_pkg::KIND_PEER_ID, b, '0, '0, fin,
                            pwsp_pkg::ERR_HASH_MISMATCH, 8'd0);
            end
            pwsp_pkg::PH_LEN: begin
               msg_len    = {msg_len[23:0], b};
               beat_count = beat_count + 1;
               if (beat_count >= pwsp_pkg::LENGTH_BYTES) begin
                  beat_count = '0;
                  if (msg_len == '0)
                     queue_result(pwsp_pkg::KIND_KEEP_ALIVE, 8'd0, '0, '0, 1'b0,
                                  pwsp_pkg::ERR_HASH_MISMATCH, 8'd0);
                  else
                     wire_phase = pwsp_pkg::PH_BODY;
               end
            end
            pwsp_pkg::PH_BODY: begin
               pos        = beat_count;
               fin        = (pos == msg_len - 1);
               beat_count = beat_count + 1;
               if (fin) begin
                  beat_count = '0;
                  msg_len    = '0;
                  wire_phase = pwsp_pkg::PH_LEN;
               end
               if (pos == '0) begin
                  msg_id = b;
                  if (b != pwsp_pkg::PIECE_ID)
                     queue_result(pwsp_pkg::KIND_ERROR, 8'd0, '0, '0, 1'b0,
                                  pwsp_pkg::ERR_NOT_PIECE, b);
               end else if (msg_id == pwsp_pkg::PIECE_ID) begin
                  if (pos <= 4)
                     piece_idx = {piece_idx[23:0], b};
                  else if (pos <= 8)
                     piece_off = {piece_off[23:0], b};
               end
               if (msg_id == pwsp_pkg::PIECE_ID) begin
                  if (pos + 1 < pwsp_pkg::PIECE_HEADER_END) begin
                     if (fin)
                        queue_result(pwsp_pkg::KIND_ERROR, 8'd0, '0, '0, 1'b0,
                                     pwsp_pkg::ERR_SHORT_PIECE, pwsp_pkg::PIECE_ID);
                  end else if (pos + 1 == pwsp_pkg::PIECE_HEADER_END) begin
                     queue_result(pwsp_pkg::KIND_HEADER, 8'd0, piece_idx, piece_off, fin,
                                  pwsp_pkg::ERR_HASH_MISMATCH, 8'd0);
                  end else begin
                     queue_result(pwsp_pkg::KIND_DATA, b, '0, '0, fin,
                                  pwsp_pkg::ERR_HASH_MISMATCH, 8'd0);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   endtask

   task automatic note_miss(input string what, input pwsp_pkg::rsp_type want,
                            input pwsp_pkg::rsp_type got);
      if (miss_total < 10) begin
         $display("%s at %0t:", what, $realtime);
         $display("  expected kind=%0d data=%02h idx=%08h off=%08h last=%0b code=%0d id=%02h",
                  want.kind, want.data_byte, want.piece_index, want.block_offset,
                  want.last, want.error_code, want.message_id);
         $display("  actual   kind=%0d data=%02h idx=%08h off=%08h last=%0b code=%0d id=%02h",
                  got.kind, got.data_byte, got.piece_index, got.block_offset,
                  got.last, got.error_code, got.message_id);
      end
      miss_total++;
   endtask

   always @(posedge clock) begin : watch
      pwsp_pkg::rsp_type want;
      pwsp_pkg::rsp_type got;
      if (reset) begin
         restart_parse();
         want_hash = '0;
         due_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind         = rsp_kind;
            got.data_byte    = rsp_data_byte;
            got.piece_index  = rsp_piece_index;
            got.block_offset = rsp_block_offset;
            got.last         = rsp_last;
            got.error_code   = rsp_error_code;
            got.message_id   = rsp_message_id;
            seen_total++;
            if (due_q.size() == 0) begin
               want = '0;
               note_miss("Unexpected result beat", want, got);
            end else begin
               want = due_q.pop_front();
               if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                   got.piece_index !== want.piece_index ||
                   got.block_offset !== want.block_offset ||
                   got.last !== want.last || got.error_code !== want.error_code ||
                   got.message_id !== want.message_id)
                  note_miss("Wrong result beat", want, got);
            end
         end
         if (csr_we) begin
            case (csr_index)
               pwsp_pkg::CSR_INFO_HASH_HIGH:   want_hash[159:96] = csr_wdata;
               pwsp_pkg::CSR_INFO_HASH_MIDDLE: want_hash[95:32]  = csr_wdata;
               pwsp_pkg::CSR_INFO_HASH_LOW:    want_hash[31:0]   = csr_wdata[31:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) follow_beat(req_action, req_rx_byte);
      end
      mismatch_count  <= miss_total;
      results_due     <= due_q.size();
      results_checked <= seen_total;
   end

endmodule

>>> tb/sv/peer_wire_stream_parser_test.sv
// Top of the peer wire stream parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module peer_wire_stream_parser_test;

   localparam int unsigned RANDOM_BEATS = 1600;
   localparam int unsigned PHASE_BEATS  = 320;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_LIMIT  = 20000;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_action;
   logic [7:0]                       req_rx_byte;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [2:0]                       rsp_kind;
   logic [7:0]                       rsp_data_byte;
   logic [31:0]                      rsp_piece_index;
   logic [31:0]                      rsp_block_offset;
   logic                             rsp_last;
   logic [1:0]                       rsp_error_code;
   logic [7:0]                       rsp_message_id;
   logic                             csr_we;
   logic [pwsp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pwsp_pkg::CSR_DATA_W-1:0]  csr_wdata;

   int unsigned  mismatch_count;
   int unsigned  results_due;
   int unsigned  results_checked;
   int unsigned  cycle_count = 0;
   int unsigned  beats_sent  = 0;
   int unsigned  hash_loads  = 0;
   logic [159:0] peer_hash   = '0;
   bit           send_calm   = 1'b0;
   bit           rsp_calm    = 1'b0;
   bit           hold_go     = 1'b0;
   bit           rsp_blocked = 1'b0;

   peer_wire_stream_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_piece_index  (rsp_piece_index),
      .rsp_block_offset (rsp_block_offset),
      .rsp_last         (rsp_last),
      .rsp_error_code   (rsp_error_code),
      .rsp_message_id   (rsp_message_id),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   peer_wire_stream_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_piece_index  (rsp_piece_index),
      .rsp_block_offset (rsp_block_offset),
      .rsp_last         (rsp_last),
      .rsp_error_code   (rsp_error_code),
      .rsp_message_id   (rsp_message_id),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .results_due      (results_due),
      .results_checked  (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [7:0] other_id();
      logic [7:0] id;
      id = 8'($urandom_range(0, 255));
      while (id == pwsp_pkg::PIECE_ID) id = 8'($urandom_range(0, 255));
      return id;
   endfunction

   task automatic send_beat(input logic act, input logic [7:0] b);
      int unsigned gap;
      if (beats_sent % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
      gap = send_calm ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_rand(input int unsigned count);
      repeat (count) send_beat(1'b0, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) send_beat(1'b0, w[8*i +: 8]);
   endtask

   task automatic handshake(input int unsigned nl, input int bad_pos);
      logic [7:0] b;
      send_beat(1'b0, nl[7:0]);
      send_rand(nl + pwsp_pkg::RESERVED_BYTES);
      for (int k = 0; k < 20; k++) begin
         b = peer_hash[159 - 8*k -: 8];
         if (k == bad_pos) b = b ^ 8'($urandom_range(1, 255));
         send_beat(1'b0, b);
      end
   endtask

   task automatic send_piece(input logic [31:0] idx, input logic [31:0] off,
                             input int unsigned dlen);
      send_word(pwsp_pkg::PIECE_HEADER_END + dlen);
      send_beat(1'b0, pwsp_pkg::PIECE_ID);
      send_word(idx);
      send_word(off);
      send_rand(dlen);
   endtask

   task automatic send_short(input int unsigned len);
      send_word(len);
      send_beat(1'b0, pwsp_pkg::PIECE_ID);
      send_rand(len - 1);
   endtask

   task automatic send_other(input logic [7:0] id, input int unsigned body);
      send_word(body + 1);
      send_beat(1'b0, id);
      send_rand(body);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (results_due != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic load_hash(input logic [159:0] h);
      csr_we    <= 1'b1;
      csr_index <= pwsp_pkg::CSR_INFO_HASH_HIGH;
      csr_wdata <= h[159:96];
      @(posedge clock);
      csr_index <= pwsp_pkg::CSR_INFO_HASH_MIDDLE;
      csr_wdata <= h[95:32];
      @(posedge clock);
      csr_index <= pwsp_pkg::CSR_INFO_HASH_LOW;
      csr_wdata <= {$urandom, h[31:0]};
      @(posedge clock);
      csr_we    <= 1'b0;
      peer_hash = h;
      hash_loads++;
   endtask

   task automatic run_session(input bit hog);
      int unsigned nl;
      int unsigned n;
      int unsigned pick;
      int          bad_pos;
      bit          live;
      logic [31:0] huge;
      live = 1'b1;
      send_beat(1'b1, 8'($urandom_range(0, 255)));
      pick    = $urandom_range(0, 19);
      nl      = (pick == 0) ? 255 : (pick < 4) ? 19 : $urandom_range(0, 6);
      bad_pos = (!hog && $urandom_range(0, 5) == 0) ? int'($urandom_range(0, 19)) : -1;
      handshake(nl, bad_pos);
      if (bad_pos >= 0) begin
         send_rand($urandom_range(0, 4));
         live = 1'b0;
      end else if (!hog && $urandom_range(0, 11) == 0) begin
         send_rand($urandom_range(0, 19));
         live = 1'b0;
      end else begin
         send_rand(pwsp_pkg::HASH_BYTES);
      end
      if (live && hog) begin
         hold_go = 1'b1;
         send_piece($urandom, $urandom, 40);
      end
      n = $urandom_range(1, 8);
      while (live && n != 0) begin
         n--;
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1: send_word(32'd0);
            2, 3, 4, 5: begin
               send_piece($urandom, $urandom, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(13, 40) : $urandom_range(0, 12));
            end
            6: send_short($urandom_range(1, 8));
            7, 8: send_other(other_id(), $urandom_range(0, 10));
            default: begin
               huge        = $urandom;
               huge[31:24] = 8'($urandom_range(1, 255));
               send_word(huge);
               if ($urandom_range(0, 1) == 0) begin
                  send_beat(1'b0, pwsp_pkg::PIECE_ID);
                  send_rand($urandom_range(0, 14));
               end else begin
                  send_beat(1'b0, other_id());
                  send_rand($urandom_range(0, 5));
               end
               live = 1'b0;
            end
         endcase
      end
   endtask

   initial begin : rsp_side
      int unsigned gap;
      int unsigned taken;
      taken = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 48 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         gap = rsp_calm ? 0 : $urandom_range(0, 11);
         if (gap != 0 || rsp_blocked) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (rsp_blocked) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin : rsp_hold
      wait (hold_go);
      rsp_blocked = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_blocked = 1'b0;
   end

   initial begin : stimulus
      logic [159:0] h;
      int unsigned  phase_no;
      int unsigned  start;
      int unsigned  target;
      int unsigned  drain;
      bit           first;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_action  <= 1'b0;
      req_rx_byte <= 8'd0;
      csr_we      <= 1'b0;
      csr_index   <= pwsp_pkg::CSR_INFO_HASH_HIGH;
      csr_wdata   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed pass against the all-zero hash left by reset
      send_beat(1'b1, 8'hFF);
      handshake(0, -1);
      for (int k = 0; k < 20; k++) send_beat(1'b0, k[0] ? 8'hFF : 8'h00);
      send_word(32'd0);
      send_piece(32'hFFFF_FFFF, 32'h0000_0000, 0);
      send_piece(32'h0000_0000, 32'hFFFF_FFFF, 1);
      send_short(1);
      send_short(8);
      send_other(8'h00, 0);
      send_other(8'hFF, 2);
      send_word(32'hFFFF_FFFF);
      send_beat(1'b0, pwsp_pkg::PIECE_ID);
      send_rand(10);
      send_beat(1'b1, 8'h00);
      handshake(1, 19);
      send_rand(3);
      send_beat(1'b1, 8'h00);
      handshake(0, 0);
      send_beat(1'b1, 8'h5A);
      send_beat(1'b0, 8'h00);
      send_rand(12);
      send_beat(1'b1, 8'hA5);
      quiesce();

      target   = beats_sent + RANDOM_BEATS;
      phase_no = 0;
      while (beats_sent < target) begin
         case (phase_no)
            0:       h = '1;
            2:       h = {{20{8'hAA}}} ^ {80'd0, {10{8'hFF}}};
            default: h = {$urandom, $urandom, $urandom, $urandom, $urandom};
         endcase
         load_hash(h);
         start = beats_sent;
         first = 1'b1;
         while (beats_sent - start < PHASE_BEATS && beats_sent < target) begin
            run_session(phase_no == 1 && first);
            first = 1'b0;
         end
         quiesce();
         phase_no++;
      end

      req_valid <= 1'b0;
      drain = 0;
      while (results_due != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      $display("Sent %0d request beats under %0d info hash settings, checked %0d results.",
               beats_sent, hash_loads + 1, results_checked);
      $display({"Covered bad hashes, keep-alives, pieces, short and foreign messages,",
                " restarts and a long result stall."});
      if (mismatch_count == 0 && results_due == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
